// ----- hw/rtl/fms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fms_pkg
// shared types and constants of the frame median select block
// ----------------------------------------------------------------------------
package fms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEDIAN_W = 17;
  localparam int COUNT_W  = 11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  // control shared by every cell of the sorting chain
  typedef struct packed {
    logic insert;  // place the broadcast sample at its rank
    logic shift;   // move every entry one cell toward the head
  } chain_ctrl_t;

endpackage

// ----- hw/rtl/fms_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fms_cell
// one entry of the sorted chain, with its insert and shift logic
// ----------------------------------------------------------------------------
module fms_cell #(
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  fms_pkg::chain_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  fms_pkg::sample_t    sample,
  input  fms_pkg::sample_t    prev_value,
  input  logic                prev_gt,
  input  fms_pkg::sample_t    next_value,
  output fms_pkg::sample_t    value,
  output logic                gt
);

  logic occupied;
  logic tail;

  assign occupied = CW'(IDX) < count;
  assign tail     = CW'(IDX) == count;
  assign gt       = occupied && (value > sample);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      // entries above the new sample move up one place
      if (gt || tail) begin
        value <= prev_gt ? prev_value : sample;
      end
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule

// ----- hw/rtl/fms_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fms_chain
// row of sorting cells, entry 0 holds the smallest sample
// ----------------------------------------------------------------------------
module fms_chain #(
  parameter int DEPTH = 1024,
  parameter int CW    = 11
) (
  input  logic                 clk,
  input  fms_pkg::chain_ctrl_t ctrl,
  input  logic [CW-1:0]        count,
  input  fms_pkg::sample_t     sample,
  output fms_pkg::sample_t     head
);

  fms_pkg::sample_t values [DEPTH];
  logic             gts    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fms_pkg::sample_t prev_v;
    fms_pkg::sample_t next_v;
    logic             prev_g;

    if (i == 0) begin : g_first
      assign prev_v = sample;
      assign prev_g = 1'b0;
    end else begin : g_inner
      assign prev_v = values[i-1];
      assign prev_g = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = values[i];
    end else begin : g_body
      assign next_v = values[i+1];
    end

    fms_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .sample     (sample),
      .prev_value (prev_v),
      .prev_gt    (prev_g),
      .next_value (next_v),
      .value      (values[i]),
      .gt         (gts[i])
    );
  end

  assign head = values[0];

endmodule

// ----- hw/rtl/frame_median_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_median_select
// median of one frame of signed samples, kept in a sorted chain of cells
// ----------------------------------------------------------------------------
// A sample transaction is taken on a rising edge with start high and busy
// low; while a frame is being collected the block takes one sample every
// cycle, since each sample is inserted at its rank in the chain as it is
// taken. The sample that carries is_last ends the frame: the block then
// raises busy and shifts the chain toward its head to pick out the middle
// entries. Busy stays high throughout the drain and drops in the cycle
// after its last shift, the same cycle in which done is high for exactly
// one cycle with median_twice, sample_count and overflow; the receiver
// cannot stall, so these must be captured in that cycle. A new frame may
// start in the cycle done is high. Samples beyond MAX_SAMPLES are dropped
// and flagged by overflow. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module frame_median_select #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [fms_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 is_last,
  output logic                                 done,
  output logic signed [fms_pkg::MEDIAN_W-1:0]  median_twice,
  output logic        [fms_pkg::COUNT_W-1:0]   sample_count,
  output logic                                 overflow
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // control state
  fms_pkg::state_t state;
  fms_pkg::state_t state_next;
  logic [CW-1:0]   count;      // samples held in the chain
  logic            dropped;    // a sample of this frame was dropped

  // drain bookkeeping
  logic [CW-1:0]    total;     // samples in the frame that just ended
  logic [CW-1:0]    step;      // shifts done so far, head holds entry step
  fms_pkg::sample_t low_mid;   // lower middle entry of an even frame

  fms_pkg::chain_ctrl_t ctrl;
  fms_pkg::sample_t     head;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] half;
  logic          at_low;
  logic          at_mid;

  assign accept   = start && !busy;
  assign has_room = count < CW'(MAX_SAMPLES);
  assign half     = total >> 1;
  assign at_low   = (half != '0) && (step == half - CW'(1));
  assign at_mid   = step == half;

  // next state and chain control
  always_comb begin
    state_next  = state;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    busy        = 1'b0;
    case (state)
      fms_pkg::ST_COLLECT: begin
        ctrl.insert = accept && has_room;
        if (accept && is_last) begin
          state_next = fms_pkg::ST_DRAIN;
        end
      end
      fms_pkg::ST_DRAIN: begin
        busy       = 1'b1;
        ctrl.shift = 1'b1;
        if (at_mid) begin
          state_next = fms_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_next = fms_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fms_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // fill count, drop flag and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == fms_pkg::ST_DRAIN) begin
        if (at_mid) begin
          count   <= '0;
          dropped <= 1'b0;
          done    <= 1'b1;
        end
      end else if (accept) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

  // frame length, drain step and result payload
  always_ff @(posedge clk) begin
    if (state == fms_pkg::ST_COLLECT) begin
      step  <= '0;
      total <= has_room ? count + CW'(1) : count;
    end else begin
      step <= step + CW'(1);
      if (at_low) begin
        low_mid <= head;
      end
      if (at_mid) begin
        sample_count <= fms_pkg::COUNT_W'(total);
        overflow     <= dropped;
        if (total == '0) begin
          median_twice <= '0;
        end else if (total[0]) begin
          median_twice <= {head, 1'b0};
        end else begin
          median_twice <= $signed({low_mid[fms_pkg::SAMPLE_W-1], low_mid})
                        + $signed({head[fms_pkg::SAMPLE_W-1], head});
        end
      end
    end
  end

  fms_chain #(
    .DEPTH (MAX_SAMPLES),
    .CW    (CW)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .count  (count),
    .sample (sample),
    .head   (head)
  );

  // the chain never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("fill count beyond capacity");

  // a result leaves the block collecting an empty frame
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == fms_pkg::ST_COLLECT && count == '0 && !dropped))
    else $error("result strobe without cleared frame state");

  // a result follows only the end of a drain
  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state) == fms_pkg::ST_DRAIN)
    else $error("result strobe outside a drain");

  // the drain never runs past the middle entry
  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    state == fms_pkg::ST_DRAIN |-> step <= half)
    else $error("drain ran past the middle entry");

endmodule
